FILE: hw/rtl/sms_pkg.sv
// Shared definitions for the sorted multiset store: field widths, opcodes,
// status codes and the compare result type. No dependencies.
`timescale 1ns / 1ps

package sms_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int ENTRY_COUNT_W = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

FILE: hw/rtl/sms_if.sv
// Valid/ready channel interfaces for the operation and result items.
// Depends on sms_pkg for the field widths.
`timescale 1ns / 1ps

interface sms_in_if import sms_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [VALUE_W-1:0] item_value;

  modport source (output valid, output op, output item_value, input ready);
  modport sink (input valid, input op, input item_value, output ready);
endinterface

interface sms_out_if import sms_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [ENTRY_COUNT_W-1:0]   entry_count;
  logic signed [VALUE_W-1:0]  smallest_value;
  logic signed [VALUE_W-1:0]  largest_value;

  modport source (output valid, output status, output entry_count,
                  output smallest_value, output largest_value, input ready);
  modport sink (input valid, input status, input entry_count,
                input smallest_value, input largest_value, output ready);
endinterface

FILE: hw/rtl/sms_cmp.sv
// Shared signed compare unit used by every scan step of the store.
// Depends on sms_pkg.
`timescale 1ns / 1ps

module sms_cmp import sms_pkg::*; (
  input  logic signed [VALUE_W-1:0] a,
  input  logic signed [VALUE_W-1:0] b,
  output cmp_res_t                  res
);

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
    res.gt = (a > b);
  end

endmodule

FILE: hw/rtl/sorted_multiset_store.sv
// Sorted multiset store: the top level with its sequencer and entry memory.
// Depends on sms_pkg, sms_if and sms_cmp.
//
// Usage: each item on in_ch inserts (op 0) or deletes one copy of (op 1)
// a signed value. The store keeps up to CAPACITY values in ascending order,
// duplicates allowed. Each item yields one result item on out_ch with a
// status, the entry count, and the smallest and largest stored values (both
// 0 when the store is empty). An insert into a full store is rejected.
// The block works on one item at a time and in_ch.ready is high only while
// it is idle. One read port, one write port and one comparator serve every
// step, and each entry visited takes a read state and a compare or write
// state. An insert scans down from the top entry, shifting each larger entry
// up by one; a delete scans up from entry 0 until it finds its value, meets a
// larger entry or runs out, then shifts the later entries down. Unless the
// store is then empty, every item next reads the smallest and largest entries;
// a rejected insert goes straight to that step. in_ch.ready rises at the
// same edge that loads the result. The result sits in an output register, so
// the next item is accepted while it waits; a stalled receiver stalls the
// input only once a second result is ready. Reset empties the store and
// drops any pending result.
`timescale 1ns / 1ps

module sorted_multiset_store import sms_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  sms_in_if.sink       in_ch,
  sms_out_if.source    out_ch
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int ST_W  = 4;

  localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
  localparam logic [ST_W-1:0] ST_INS_RD  = 4'd1;
  localparam logic [ST_W-1:0] ST_INS_CMP = 4'd2;
  localparam logic [ST_W-1:0] ST_DEL_RD  = 4'd3;
  localparam logic [ST_W-1:0] ST_DEL_CMP = 4'd4;
  localparam logic [ST_W-1:0] ST_SH_RD   = 4'd5;
  localparam logic [ST_W-1:0] ST_SH_WR   = 4'd6;
  localparam logic [ST_W-1:0] ST_MIN_RD  = 4'd7;
  localparam logic [ST_W-1:0] ST_MIN_WT  = 4'd8;
  localparam logic [ST_W-1:0] ST_MAX_WT  = 4'd9;
  localparam logic [ST_W-1:0] ST_DONE    = 4'd10;

  logic signed [VALUE_W-1:0] mem [CAPACITY];
  logic signed [VALUE_W-1:0] rd_data_r;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_wa;
  logic [IDX_W-1:0]          mem_ra;
  logic signed [VALUE_W-1:0] mem_wd;

  logic [ST_W-1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          i_r, i_nxt;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic signed [VALUE_W-1:0] small_r, small_nxt;
  logic signed [VALUE_W-1:0] large_r, large_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_load;

  logic [STATUS_W-1:0]       out_status_r;
  logic [ENTRY_COUNT_W-1:0]  out_count_r;
  logic signed [VALUE_W-1:0] out_small_r;
  logic signed [VALUE_W-1:0] out_large_r;

  logic [CNT_W-1:0]          i_inc;
  logic [CNT_W-1:0]          i_dec;
  logic [CNT_W-1:0]          count_dec;
  cmp_res_t                  cmp;

  sms_cmp u_cmp (
    .a   (rd_data_r),
    .b   (val_r),
    .res (cmp)
  );

  assign i_inc     = i_r + CNT_W'(1);
  assign i_dec     = i_r - CNT_W'(1);
  assign count_dec = count_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    status_nxt    = status_r;
    val_nxt       = val_r;
    small_nxt     = small_r;
    large_nxt     = large_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = i_r[IDX_W-1:0];
    mem_wd        = val_r;
    mem_ra        = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          val_nxt    = in_ch.item_value;
          status_nxt = STATUS_DONE;
          if (in_ch.op == OP_INSERT) begin
            if (count_r == CNT_W'(CAPACITY)) begin
              status_nxt = STATUS_FULL;
              state_nxt  = ST_MIN_RD;
            end else begin
              i_nxt     = count_r;
              state_nxt = ST_INS_RD;
            end
          end else begin
            i_nxt     = '0;
            state_nxt = ST_DEL_RD;
          end
        end
      end
      ST_INS_RD: begin
        if (i_r == '0) begin
          mem_we    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = ST_MIN_RD;
        end else begin
          mem_ra    = i_dec[IDX_W-1:0];
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (cmp.gt) begin
          mem_wd    = rd_data_r;
          i_nxt     = i_dec;
          state_nxt = ST_INS_RD;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          state_nxt = ST_MIN_RD;
        end
      end
      ST_DEL_RD: begin
        if (i_r == count_r) begin
          status_nxt = STATUS_NO_MATCH;
          state_nxt  = ST_MIN_RD;
        end else begin
          mem_ra    = i_r[IDX_W-1:0];
          state_nxt = ST_DEL_CMP;
        end
      end
      ST_DEL_CMP: begin
        priority if (cmp.eq) begin
          state_nxt = ST_SH_RD;
        end else if (cmp.gt) begin
          status_nxt = STATUS_NO_MATCH;
          state_nxt  = ST_MIN_RD;
        end else begin
          i_nxt     = i_inc;
          state_nxt = ST_DEL_RD;
        end
      end
      ST_SH_RD: begin
        if (i_inc == count_r) begin
          count_nxt = count_dec;
          state_nxt = ST_MIN_RD;
        end else begin
          mem_ra    = i_inc[IDX_W-1:0];
          state_nxt = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_wd    = rd_data_r;
        i_nxt     = i_inc;
        state_nxt = ST_SH_RD;
      end
      ST_MIN_RD: begin
        if (count_r == '0) begin
          small_nxt = '0;
          large_nxt = '0;
          state_nxt = ST_DONE;
        end else begin
          mem_ra    = '0;
          state_nxt = ST_MIN_WT;
        end
      end
      ST_MIN_WT: begin
        small_nxt = rd_data_r;
        mem_ra    = count_dec[IDX_W-1:0];
        state_nxt = ST_MAX_WT;
      end
      ST_MAX_WT: begin
        large_nxt = rd_data_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      i_r         <= '0;
      status_r    <= STATUS_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      i_r         <= i_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    small_r <= small_nxt;
    large_r <= large_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_count_r  <= ENTRY_COUNT_W'(count_r);
      out_small_r  <= small_r;
      out_large_r  <= large_r;
    end
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.entry_count    = out_count_r;
  assign out_ch.smallest_value = out_small_r;
  assign out_ch.largest_value  = out_large_r;

endmodule

FILE: hw/rtl/sms_checker.sv
// Port-level checks for the sorted multiset store and the bind that
// attaches them to the top level. Depends on sms_pkg and the top level.
`timescale 1ns / 1ps

module sms_checker import sms_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [STATUS_W-1:0]       status,
  input logic [ENTRY_COUNT_W-1:0]  entry_count,
  input logic signed [VALUE_W-1:0] smallest_value,
  input logic signed [VALUE_W-1:0] largest_value
);

  // A pending result is held until the receiver takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item pending right after reset");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == STATUS_FULL) |->
      (entry_count == ENTRY_COUNT_W'(CAPACITY)))
    else $error("insert rejected while the store was not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (entry_count == '0) && (CAPACITY < 32) |->
      (smallest_value == '0) && (largest_value == '0))
    else $error("empty store reports a nonzero extreme value");

endmodule

bind sorted_multiset_store sms_checker #(
  .CAPACITY (CAPACITY)
) u_sms_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .status         (out_ch.status),
  .entry_count    (out_ch.entry_count),
  .smallest_value (out_ch.smallest_value),
  .largest_value  (out_ch.largest_value)
);

FILE: tb/sv/sorted_store_checker.sv
// Checker for the sorted multiset store: mirrors the ordered contents, predicts
// the result item of every accepted operation and compares it field by field.
// Depends on sms_pkg and the channel interfaces in sms_if.
`timescale 1ns / 1ps

module sorted_store_checker import sms_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sms_in_if    in_ch,
  sms_out_if   out_ch,
  output int   fail_count,
  output int   results_owed
);

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [ENTRY_COUNT_W-1:0]  entry_count;
    logic signed [VALUE_W-1:0] smallest_value;
    logic signed [VALUE_W-1:0] largest_value;
  } store_summary_t;

  logic signed [VALUE_W-1:0] held_values [CAPACITY];
  int                        held_count;
  store_summary_t            owed_summaries [$];

  function automatic store_summary_t apply_store_op(input logic op,
                                                    input logic signed [VALUE_W-1:0] v);
    store_summary_t r;
    int pos;
    int i;
    r.status = STATUS_DONE;
    pos = 0;
    if (op == OP_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        while (pos < held_count && held_values[pos] <= v) pos++;
        for (i = held_count; i > pos; i--) held_values[i] = held_values[i-1];
        held_values[pos] = v;
        held_count++;
      end
    end else begin
      while (pos < held_count && held_values[pos] < v) pos++;
      if (pos < held_count && held_values[pos] == v) begin
        for (i = pos; i + 1 < held_count; i++) held_values[i] = held_values[i+1];
        held_count--;
      end else begin
        r.status = STATUS_NO_MATCH;
      end
    end
    r.entry_count = held_count[ENTRY_COUNT_W-1:0];
    r.smallest_value = (held_count == 0) ? '0 : held_values[0];
    r.largest_value  = (held_count == 0) ? '0 : held_values[held_count-1];
    return r;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    held_count = 0;
  end

  always @(posedge clk) begin
    store_summary_t want;
    if (!rst_n) begin
      held_count = 0;
      owed_summaries.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        owed_summaries.push_back(apply_store_op(in_ch.op, in_ch.item_value));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (owed_summaries.size() == 0) begin
          $error("result item arrived with no operation outstanding");
          fail_count++;
        end else begin
          want = owed_summaries.pop_front();
          compare_field("status", want.status, out_ch.status);
          compare_field("entry_count", want.entry_count, out_ch.entry_count);
          compare_field("smallest_value", want.smallest_value, out_ch.smallest_value);
          compare_field("largest_value", want.largest_value, out_ch.largest_value);
        end
      end
    end
    results_owed = owed_summaries.size();
  end

endmodule

FILE: tb/sv/sorted_multiset_store_tb.sv
// Top of the sorted multiset store testbench: clock, reset, directed and
// random insert/delete items, receiver stalls and the verdict.
// Depends on sms_pkg, sms_if, sorted_multiset_store and sorted_store_checker.
`timescale 1ns / 1ps

module sorted_multiset_store_tb import sms_pkg::*;;

  localparam int RANDOM_ITEMS = 1050;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_AT      = 2500;
  localparam int HOLD_LEN     = 300;
  localparam int STEADY_FROM  = 5000;
  localparam int STEADY_TO    = 8000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_no = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   results_owed;
  logic steady;

  sms_in_if  in_ch ();
  sms_out_if out_ch ();

  sorted_multiset_store #(.CAPACITY(CAPACITY_DEF)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sorted_store_checker #(.CAPACITY(CAPACITY_DEF)) checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  assign steady = (cycle_no >= STEADY_FROM) && (cycle_no < STEADY_TO);

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver stalls at random, and once holds off long enough for the
  // store to fill its output register and stop taking items.
  initial begin
    int hold_left;
    int rx_cycle;
    hold_left = 0;
    rx_cycle = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n && (steady || ($urandom_range(0, 99) >= 25));
      end
    end
  end

  logic signed [VALUE_W-1:0] recent_inserts [$];

  task automatic offer_op(input logic op, input logic signed [VALUE_W-1:0] v);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= 1'($urandom);
      in_ch.item_value <= $urandom;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.item_value <= v;
    if (op == OP_INSERT) begin
      recent_inserts.push_back(v);
      if (recent_inserts.size() > 32) void'(recent_inserts.pop_front());
    end
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return int'($urandom_range(0, 16)) - 8;
    if (sel < 50) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int insert_pct;
    int idx;
    logic op;
    logic signed [VALUE_W-1:0] v;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_INSERT;
    in_ch.item_value <= '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    offer_op(OP_DELETE, 5);
    offer_op(OP_INSERT, 7);
    offer_op(OP_DELETE, 7);
    offer_op(OP_INSERT, 32'sh8000_0000);
    offer_op(OP_INSERT, 32'sh7FFF_FFFF);
    offer_op(OP_INSERT, 0);
    offer_op(OP_INSERT, 0);
    offer_op(OP_DELETE, 0);
    offer_op(OP_DELETE, 5);
    offer_op(OP_INSERT, 32'sh5555_5555);
    offer_op(OP_INSERT, 32'shAAAA_AAAA);
    offer_op(OP_INSERT, 1);
    offer_op(OP_INSERT, -1);
    for (int j = 0; j < 9; j++) offer_op(OP_INSERT, $urandom);
    offer_op(OP_INSERT, 3);
    offer_op(OP_DELETE, 32'sh8000_0000);
    offer_op(OP_DELETE, 32'sh7FFF_FFFF);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      case ((k / 60) % 3)
        0: insert_pct = 80;
        1: insert_pct = 50;
        default: insert_pct = 20;
      endcase
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
      if (op == OP_DELETE && recent_inserts.size() > 0 && $urandom_range(0, 99) < 75) begin
        idx = $urandom_range(0, recent_inserts.size() - 1);
        v = recent_inserts[idx];
        recent_inserts.delete(idx);
      end else begin
        v = pick_value();
      end
      offer_op(op, v);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/sms_pkg.sv
hw/rtl/sms_if.sv
hw/rtl/sms_cmp.sv
hw/rtl/sorted_multiset_store.sv
hw/rtl/sms_checker.sv
tb/sv/sorted_store_checker.sv
tb/sv/sorted_multiset_store_tb.sv
